>>> src/equivalence_closure_labeler_top_assert.svh
// Assertion macros shared by the labeler modules.
// ECL_ASSERT is disabled while reset is held; ECL_ASSERT_ALWAYS checks at every edge.
`ifndef EQUIVALENCE_CLOSURE_LABELER_TOP_ASSERT_SVH
`define EQUIVALENCE_CLOSURE_LABELER_TOP_ASSERT_SVH
`ifndef SYNTH
`define ECL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECL_ASSERT(lbl, prop, msg)
`define ECL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/ecl_pkg.sv
package ecl_pkg;

    localparam int MAX_NODES  = 16;
    localparam int NODE_LIMIT = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int NODE_COUNT_RESET = 16;

    localparam logic CMD_PAIR = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [MAX_NODES-1:0] row_t;

    // controller -> datapath
    typedef struct packed {
        logic run_start;
        logic load_pair;
        logic sym_step;
        logic load_k;
        logic warsh_step;
        logic label_step;
        logic clear_mat;
        logic emit_step;
        idx_t row_idx;
        idx_t k_idx;
    } ecl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        idx_t last_idx;
        logic out_free;
    } ecl_status_t;

endpackage

>>> src/equivalence_closure_labeler_top.sv
// Equivalence-class labeler over a 16 x 16 relation bit matrix.
// Input channel (in_valid / in_stall; request taken when valid and not stall):
//   cmd = 0 marks pair (node_a, node_b) related: one matrix bit, no result.
//   cmd = 1 runs: symmetric/reflexive closure, Warshall transitive closure, class
//   labeling, then one result per node 0..n-1, with last on node n-1.
// Config channel (cfg_valid / cfg_ready, ready always high): cfg_data = node_count,
//   clamped to 1..16 internally; write it only while the block is idle.
// Output channel (out_valid / out_stall): registered; a stall holds the payload.
// Run sequence for n active nodes: a symmetric sweep over the rows, then
//   Warshall (one pivot-row load plus an update of each active row per pivot,
//   one matrix row per cycle), then labeling, then one result per cycle while
//   not stalled. in_stall stays high for the whole run. Pair requests sustain
//   one per cycle while the block is idle.
// The matrix is cleared when labeling ends, ready for the next load.
// Reset: matrix cleared, node_count = 16, output empty, controller idle.
module equivalence_closure_labeler_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  ecl_pkg::idx_t       node_a,
    input  ecl_pkg::idx_t       node_b,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ecl_pkg::cnt_t       cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ecl_pkg::idx_t       node_index,
    output ecl_pkg::idx_t       class_number,
    output ecl_pkg::cnt_t       representative,
    output ecl_pkg::cnt_t       class_count,
    output logic                last
);
    import ecl_pkg::*;

    ecl_cmd_t    ctl;    // step commands and row/pivot indexes
    ecl_status_t status; // active node range and output room

    // sequencer: walks rows, pivots and nodes
    ecl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_stall (in_stall),
        .status   (status),
        .ctl      (ctl)
    );

    // matrix, label tables, config register and output register
    ecl_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .node_a         (node_a),
        .node_b         (node_b),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .node_index     (node_index),
        .class_number   (class_number),
        .representative (representative),
        .class_count    (class_count),
        .last           (last)
    );

endmodule

>>> src/ecl_ctrl.sv
`include "equivalence_closure_labeler_top_assert.svh"

module ecl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_stall,
    input  ecl_pkg::ecl_status_t status,
    output ecl_pkg::ecl_cmd_t    ctl
);
    import ecl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SYM   = 6'b000010,
        ST_LOADK = 6'b000100,
        ST_WARSH = 6'b001000,
        ST_LABEL = 6'b010000,
        ST_EMIT  = 6'b100000
    } ecl_state_t;

    ecl_state_t state_reg, state_next;
    idx_t       i_reg, i_next;
    idx_t       k_reg, k_next;
    logic       i_at_last;
    logic       k_at_last;

    assign i_at_last = (i_reg == status.last_idx);
    assign k_at_last = (k_reg == status.last_idx);

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        ctl         = '0;
        ctl.row_idx = i_reg;
        ctl.k_idx   = k_reg;
        in_stall    = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_RUN)
                    begin
                        ctl.run_start = 1'b1;
                        i_next        = '0;
                        state_next    = ST_SYM;
                    end
                    else
                    begin
                        ctl.load_pair = 1'b1;
                    end
                end
            end
            ST_SYM:
            begin
                ctl.sym_step = 1'b1;
                if (i_at_last)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_LOADK;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_LOADK:
            begin
                // pivot row is read through the single row port
                ctl.load_k  = 1'b1;
                ctl.row_idx = k_reg;
                i_next      = '0;
                state_next  = ST_WARSH;
            end
            ST_WARSH:
            begin
                ctl.warsh_step = 1'b1;
                if (i_at_last)
                begin
                    i_next = '0;
                    if (k_at_last)
                    begin
                        state_next = ST_LABEL;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_LOADK;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_LABEL:
            begin
                ctl.label_step = 1'b1;
                if (i_at_last)
                begin
                    ctl.clear_mat = 1'b1;
                    i_next        = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    ctl.emit_step = 1'b1;
                    if (i_at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    `ECL_ASSERT(a_emit_needs_room, ctl.emit_step |-> status.out_free, "emit into full output")
    `ECL_ASSERT(a_run_starts_sym, (state_reg == ST_IDLE) && in_valid && (in_cmd == CMD_RUN) |=> (state_reg == ST_SYM), "run request did not start")
    `ECL_ASSERT(a_row_in_range, (state_reg != ST_IDLE) |-> (i_reg <= status.last_idx), "row counter past active nodes")

endmodule

>>> src/ecl_dpath.sv
`include "equivalence_closure_labeler_top_assert.svh"

module ecl_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecl_pkg::ecl_cmd_t    ctl,
    output ecl_pkg::ecl_status_t status,
    input  ecl_pkg::idx_t        node_a,
    input  ecl_pkg::idx_t        node_b,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  ecl_pkg::cnt_t        cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ecl_pkg::idx_t        node_index,
    output ecl_pkg::idx_t        class_number,
    output ecl_pkg::cnt_t        representative,
    output ecl_pkg::cnt_t        class_count,
    output logic                 last
);
    import ecl_pkg::*;

    cnt_t node_count_reg;
    cnt_t n_act;
    row_t mask;

    row_t rows_reg [MAX_NODES];
    row_t rows_next [MAX_NODES];
    row_t rowk_reg;
    row_t sel_row;
    row_t col_sel;
    row_t members;
    cnt_t rep_val;
    logic new_class;

    row_t labeled_reg, labeled_next;
    cnt_t classes_reg, classes_next;
    idx_t class_of_reg [MAX_NODES];
    cnt_t class_rep_reg [MAX_NODES];
    idx_t emit_class;

    logic out_valid_reg;
    idx_t node_index_reg;
    idx_t class_number_reg;
    cnt_t representative_reg;
    cnt_t class_count_reg;
    logic last_reg;

    assign cfg_ready = 1'b1;

    // clamp node count to 1..NODE_LIMIT
    always_comb
    begin
        if (node_count_reg == '0)
            n_act = CNT_W'(1);
        else if (node_count_reg > CNT_W'(NODE_LIMIT))
            n_act = CNT_W'(NODE_LIMIT);
        else
            n_act = node_count_reg;
    end

    always_comb
    begin
        for (int j = 0; j < MAX_NODES; j++)
        begin
            mask[j]    = (CNT_W'(j) < n_act);
            col_sel[j] = rows_reg[j][ctl.row_idx] & mask[j];
        end
    end

    assign status.last_idx = IDX_W'(n_act - 1'b1);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign sel_row   = rows_reg[ctl.row_idx];
    assign members   = sel_row & mask;
    assign new_class = ctl.label_step && !labeled_reg[ctl.row_idx];

    // largest member + 1
    always_comb
    begin
        rep_val = '0;
        for (int j = 0; j < MAX_NODES; j++)
        begin
            if (members[j])
                rep_val = CNT_W'(j + 1);
        end
    end

    // relation matrix update
    always_comb
    begin
        rows_next = rows_reg;
        priority if (ctl.clear_mat)
        begin
            for (int j = 0; j < MAX_NODES; j++)
                rows_next[j] = '0;
        end
        else if (ctl.load_pair)
        begin
            if (({1'b0, node_a} < CNT_W'(MAX_NODES)) && ({1'b0, node_b} < CNT_W'(MAX_NODES)))
                rows_next[node_a][node_b] = 1'b1;
        end
        else if (ctl.sym_step)
        begin
            rows_next[ctl.row_idx] = members | col_sel | (row_t'(1) << ctl.row_idx);
        end
        else if (ctl.warsh_step)
        begin
            if (sel_row[ctl.k_idx])
                rows_next[ctl.row_idx] = sel_row | rowk_reg;
        end
    end

    always_comb
    begin
        labeled_next = labeled_reg;
        classes_next = classes_reg;
        priority if (ctl.run_start)
        begin
            labeled_next = '0;
            classes_next = '0;
        end
        else if (new_class)
        begin
            labeled_next = labeled_reg | members;
            classes_next = classes_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(NODE_COUNT_RESET);
            for (int j = 0; j < MAX_NODES; j++)
                rows_reg[j] <= '0;
            labeled_reg   <= '0;
            classes_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
            rows_reg    <= rows_next;
            labeled_reg <= labeled_next;
            classes_reg <= classes_next;
            if (ctl.emit_step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign emit_class = class_of_reg[ctl.row_idx];

    // label tables and output payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load_k)
            rowk_reg <= sel_row;
        if (new_class)
        begin
            for (int j = 0; j < MAX_NODES; j++)
            begin
                if (members[j])
                    class_of_reg[j] <= classes_reg[IDX_W-1:0];
            end
            class_rep_reg[classes_reg[IDX_W-1:0]] <= rep_val;
        end
        if (ctl.emit_step)
        begin
            node_index_reg     <= ctl.row_idx;
            class_number_reg   <= emit_class;
            representative_reg <= class_rep_reg[emit_class];
            class_count_reg    <= classes_reg;
            last_reg           <= (ctl.row_idx == status.last_idx);
        end
    end

    assign out_valid      = out_valid_reg;
    assign node_index     = node_index_reg;
    assign class_number   = class_number_reg;
    assign representative = representative_reg;
    assign class_count    = class_count_reg;
    assign last           = last_reg;

    `ECL_ASSERT(a_emit_has_classes, ctl.emit_step |-> (classes_reg != '0), "emit with no classes")
    `ECL_ASSERT(a_label_covers_self, new_class |=> labeled_reg[$past(ctl.row_idx)], "new class misses its own node")

endmodule

>>> bench/testbench.sv
module testbench;
    import ecl_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 400;
    // a 16-node run plus output stalls fits well inside this limit; it leaves wide margin
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PRESSURE_PHASE = 3;

    typedef enum {ROW_CFG, ROW_PAIR, ROW_RUN} row_kind_t;
    // how a run's labels are predicted: by the model, or typed in directly
    typedef enum {CHK_MODEL, CHK_SINGLETONS, CHK_ONE_CLASS} check_t;

    typedef struct {
        row_kind_t kind;
        idx_t      a;
        idx_t      b;
        cnt_t      cfg;
        check_t    chk;
    } step_t;

    typedef struct {
        idx_t node;
        idx_t cls;
        cnt_t rep;
        cnt_t cnt;
        logic last;
    } label_t;

    // Directed part: extremes of node_count (0, 1, 4, 16, 31), pairs on the
    // matrix corners, a chain that only the transitive pass can join, pairs
    // outside the active nodes, run operands that must be ignored, and runs
    // that show the matrix was cleared by the run before.
    localparam int DIR_STEPS = 25;
    step_t dir_steps [DIR_STEPS] = '{
        '{ROW_RUN,  0,  0,  0, CHK_SINGLETONS},   // after reset: 16 lone nodes
        '{ROW_CFG,  0,  0,  0, CHK_MODEL},        // zero acts as one node
        '{ROW_RUN, 15, 15,  0, CHK_ONE_CLASS},    // run ignores node_a / node_b
        '{ROW_CFG,  0,  0, 31, CHK_MODEL},        // above range clamps to 16
        '{ROW_PAIR, 15, 0,  0, CHK_MODEL},
        '{ROW_PAIR, 0, 15,  0, CHK_MODEL},
        '{ROW_PAIR, 7,  7,  0, CHK_MODEL},
        '{ROW_PAIR, 3, 12,  0, CHK_MODEL},
        '{ROW_RUN,  0,  0,  0, CHK_MODEL},
        '{ROW_CFG,  0,  0,  4, CHK_MODEL},
        '{ROW_PAIR, 0,  1,  0, CHK_MODEL},        // chain 0-1-2-3 in mixed order
        '{ROW_PAIR, 2,  1,  0, CHK_MODEL},
        '{ROW_PAIR, 3,  2,  0, CHK_MODEL},
        '{ROW_RUN,  0,  0,  0, CHK_ONE_CLASS},
        '{ROW_PAIR, 0,  9,  0, CHK_MODEL},        // bits past n are ignored
        '{ROW_PAIR, 15, 15, 0, CHK_MODEL},
        '{ROW_PAIR, 9,  0,  0, CHK_MODEL},
        '{ROW_RUN,  0,  0,  0, CHK_SINGLETONS},
        '{ROW_CFG,  0,  0, 16, CHK_MODEL},
        '{ROW_RUN,  0,  0,  0, CHK_SINGLETONS},   // nothing left from above
        '{ROW_CFG,  0,  0,  1, CHK_MODEL},
        '{ROW_PAIR, 10, 11, 0, CHK_MODEL},
        '{ROW_RUN,  0,  0,  0, CHK_ONE_CLASS},
        '{ROW_CFG,  0,  0, 16, CHK_MODEL},
        '{ROW_RUN,  0,  0,  0, CHK_SINGLETONS}    // row 10 was cleared
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = CMD_PAIR;
    idx_t node_a = '0;
    idx_t node_b = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cnt_t cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    idx_t node_index;
    idx_t class_number;
    cnt_t representative;
    cnt_t class_count;
    logic last;

    // predictor state: relation matrix and node_count as the block holds them
    row_t rel_rows [MAX_NODES];
    cnt_t node_count_shadow = cnt_t'(NODE_COUNT_RESET);
    label_t label_q [$];

    int errors = 0;
    int pair_reqs = 0;
    int run_reqs = 0;
    int cfg_writes = 0;
    int labels_checked = 0;
    int burst_left = 0;
    bit valid_up = 0;
    bit hold_req = 0;
    int holds_done = 0;
    label_t want;

    equivalence_closure_labeler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .node_a         (node_a),
        .node_b         (node_b),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .node_index     (node_index),
        .class_number   (class_number),
        .representative (representative),
        .class_count    (class_count),
        .last           (last)
    );

    always #HALF_PERIOD clk = ~clk;

    // effective node count: 0 counts as 1, anything past the matrix as its size
    function automatic int active_count(cnt_t v);
        if (v < 1)
            return 1;
        if (v > NODE_LIMIT)
            return NODE_LIMIT;
        return int'(v);
    endfunction

    // Applies one request to the matrix; on a run, closes the relation
    // (symmetric + reflexive, then Warshall k-i-j), numbers classes in order of
    // their lowest member and queues one label per node when keep is set.
    function automatic void apply_relation_request(logic c, idx_t a, idx_t b, bit keep);
        int n;
        int classes;
        int rep;
        row_t mask;
        row_t labeled;
        row_t members;
        idx_t cls_of [MAX_NODES];
        cnt_t rep_of [MAX_NODES];
        label_t r;
        if (c == CMD_PAIR)
        begin
            rel_rows[a][b] = 1'b1;
            return;
        end
        n = active_count(node_count_shadow);
        mask = row_t'((32'd1 << n) - 1);
        for (int i = 0; i < n; i++)
            rel_rows[i] &= mask;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                if (rel_rows[i][j])
                    rel_rows[j][i] = 1'b1;
            rel_rows[i][i] = 1'b1;
        end
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (rel_rows[i][k])
                    rel_rows[i] |= rel_rows[k];
        classes = 0;
        labeled = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!labeled[i])
            begin
                members = rel_rows[i];
                rep = 0;
                for (int j = 0; j < n; j++)
                begin
                    if (members[j])
                    begin
                        labeled[j] = 1'b1;
                        cls_of[j] = idx_t'(classes);
                        rep = j + 1;
                    end
                end
                rep_of[classes] = cnt_t'(rep);
                classes++;
            end
        end
        if (keep)
        begin
            for (int i = 0; i < n; i++)
            begin
                r.node = idx_t'(i);
                r.cls  = cls_of[i];
                r.rep  = rep_of[cls_of[i]];
                r.cnt  = cnt_t'(classes);
                r.last = (i == n - 1);
                label_q.push_back(r);
            end
        end
        for (int i = 0; i < MAX_NODES; i++)
            rel_rows[i] = '0;
    endfunction

    // labels that can be written down directly: every node alone, or all joined
    function automatic void push_typed_labels(check_t chk);
        int n;
        label_t r;
        n = active_count(node_count_shadow);
        for (int i = 0; i < n; i++)
        begin
            r.node = idx_t'(i);
            r.last = (i == n - 1);
            if (chk == CHK_SINGLETONS)
            begin
                r.cls = idx_t'(i);
                r.rep = cnt_t'(i + 1);
                r.cnt = cnt_t'(n);
            end
            else
            begin
                r.cls = '0;
                r.rep = cnt_t'(n);
                r.cnt = cnt_t'(1);
            end
            label_q.push_back(r);
        end
    endfunction

    // Offers one request and holds it until taken. Afterwards the sender
    // either keeps valid up for the next request of the burst or idles.
    task automatic offer(logic c, idx_t a, idx_t b, check_t chk);
        int gap_len;
        cmd <= c;
        node_a <= a;
        node_b <= b;
        in_valid <= 1'b1;
        valid_up = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_RUN)
            run_reqs++;
        else
            pair_reqs++;
        if (chk == CHK_MODEL)
        begin
            apply_relation_request(c, a, b, 1);
        end
        else
        begin
            push_typed_labels(chk);
            apply_relation_request(c, a, b, 0);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(0, 15);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                valid_up = 0;
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    // drop valid, then wait until every label is back and the block is quiet
    task automatic settle();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 0;
        end
        while (label_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(cnt_t v);
        settle();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        node_count_shadow = v;
        cfg_writes++;
    endtask

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    // Result monitor: every accepted label is matched against the oldest one queued.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (label_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected label, expected none actual node %0d class %0d",
                         $time, node_index, class_number);
            end
            else
            begin
                want = label_q.pop_front();
                check_field("node_index", want.node, node_index);
                check_field("class_number", want.cls, class_number);
                check_field("representative", want.rep, representative);
                check_field("class_count", want.cnt, class_count);
                check_field("last", want.last, last);
                labels_checked++;
            end
        end
    end

    // Receiver: stall patterns in random stretches (open, sparse, dense,
    // periodic); on request a long hold-off so the block backs up into its input.
    initial
    begin
        int mode;
        int left;
        int tick;
        int hold;
        mode = 0;
        left = 0;
        tick = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
                if (hold == 0)
                    holds_done++;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d labels outstanding", cycles, label_q.size());
        $display("** equivalence_closure_labeler_top: FAILED **");
        $finish;
    end

    // Stimulus: directed rows first, then phases of random pairs closed by a run.
    initial
    begin
        int phase;
        int n;
        int npairs;
        int pick;
        cnt_t v;
        idx_t a;
        idx_t b;
        for (int i = 0; i < MAX_NODES; i++)
            rel_rows[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            case (dir_steps[i].kind)
                ROW_CFG:  write_node_count(dir_steps[i].cfg);
                ROW_PAIR: offer(CMD_PAIR, dir_steps[i].a, dir_steps[i].b, dir_steps[i].chk);
                default:  offer(CMD_RUN, dir_steps[i].a, dir_steps[i].b, dir_steps[i].chk);
            endcase
        end

        phase = 0;
        while (pair_reqs + run_reqs < DIR_STEPS + RANDOM_ITEMS)
        begin
            // new node_count every third phase, mostly small, now and then extreme
            if (phase % 3 == 0)
            begin
                pick = $urandom_range(0, 9);
                if (phase == PRESSURE_PHASE || pick == 1)
                    v = cnt_t'(16);
                else if (pick == 0)
                    v = '0;
                else if (pick == 2)
                    v = cnt_t'($urandom_range(17, 31));
                else if (pick == 3)
                    v = cnt_t'($urandom_range(9, 15));
                else
                    v = cnt_t'($urandom_range(1, 8));
                write_node_count(v);
            end
            n = active_count(node_count_shadow);
            npairs = $urandom_range(0, n + 2);
            repeat (npairs)
            begin
                // either node, one time in ten, is drawn at random and may fall outside the active nodes
                a = ($urandom_range(0, 9) == 0) ? idx_t'($urandom)
                                                : idx_t'($urandom_range(0, n - 1));
                b = ($urandom_range(0, 9) == 0) ? idx_t'($urandom)
                                                : idx_t'($urandom_range(0, n - 1));
                offer(CMD_PAIR, a, b, CHK_MODEL);
            end
            offer(CMD_RUN, idx_t'($urandom), idx_t'($urandom), CHK_MODEL);
            // long output hold-off over the run just taken; the next phase's
            // pairs keep coming behind it
            if (phase == PRESSURE_PHASE)
                hold_req = 1;
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pair and %0d run requests over %0d node_count writes",
                 pair_reqs, run_reqs, cfg_writes);
        $display("checked %0d labels, %0d long output hold-offs", labels_checked, holds_done);
        if (errors == 0 && label_q.size() == 0)
            $display("** equivalence_closure_labeler_top: PASSED **");
        else
            $display("** equivalence_closure_labeler_top: FAILED **");
        $finish;
    end

endmodule
